### rtl/kslpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kslpd_pkg
// Shared types and constants for the key short/long press detector.
// ----------------------------------------------------------------------------
package kslpd_pkg;

    // Widths of the configuration registers and of the per-key counters.
    localparam int LONG_W  = 16;
    localparam int GLITCH_W = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LVL  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [LONG_W-1:0]   LONG_PRESS_RST = 16'd200;
    localparam logic [GLITCH_W-1:0] GLITCH_RST     = 8'd1;

    // Command codes of an input word.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Key status codes.
    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_LONG  = 2'd2;

    // Saturation limits of the counters.
    localparam logic [LONG_W-1:0]   PRESSED_MAX  = '1;
    localparam logic [GLITCH_W-1:0] RELEASED_MAX = '1;

    // State kept for one key.
    typedef struct packed {
        logic [LONG_W-1:0]   pressed_count;
        logic [GLITCH_W-1:0] released_count;
        logic [1:0]          current_status;
        logic [1:0]          latched_status;
    } key_state_t;

endpackage

### rtl/key_short_long_press_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_short_long_press_detector
// Debounces several keys and classifies their presses as short or long.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) carries one word per handshake:
// either a tick with the raw level of every key (cmd = tick) or a request to
// read and clear the latched status of one key (cmd = read). Every input
// word gives exactly one output word on the output channel (out_valid,
// out_stall): the short and long press masks of a tick, or the status read.
// The key state of all keys is kept as one row of a synchronous memory. A
// word is read from memory on acceptance, updated in the following cycle and
// written back; the next word takes the updated row through a forwarding
// path, so a word may follow in every cycle while the output is not stalled.
// out_valid rises when the word leaves the update stage. One word per cycle is
// taken while the output is not stalled, set by the single read-modify-write
// on the state row. Reset clears all counts and statuses (the row reads as
// zero until it is first written) and loads the configuration reset values.
// When the receiver stalls, the output word holds and in_stall rises once the
// word in the update stage cannot move on; no word is lost. The user writes
// configuration through cfg_we, cfg_index and cfg_data only while idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module key_short_long_press_detector
    import kslpd_pkg::*;
#(
    parameter int NUM_KEYS = 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 cmd,
    input  logic [NUM_KEYS-1:0]  key_levels,
    input  logic [((NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1)-1:0] key_index,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [NUM_KEYS-1:0]  short_mask,
    output logic [NUM_KEYS-1:0]  long_mask,
    output logic [1:0]           read_status
);

    localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int ROW_W = NUM_KEYS * $bits(key_state_t);

    typedef key_state_t [NUM_KEYS-1:0] row_t;

    // Configuration registers.
    logic [LONG_W-1:0]   long_press_reg;
    logic [GLITCH_W-1:0] glitch_reg;
    logic [NUM_KEYS-1:0] press_level_reg;

    // Update stage registers.
    logic                s1_valid_reg;
    logic                s1_cmd_reg;
    logic [NUM_KEYS-1:0] s1_levels_reg;
    logic [IDX_W-1:0]    s1_idx_reg;

    // State memory, its read data and the forwarding path.
    logic [ROW_W-1:0]    state_mem [0:0];
    logic                mem_written_reg;
    logic [ROW_W-1:0]    rd_data_reg;
    logic                rd_zero_reg;
    logic                fwd_hit_reg;
    row_t                wb_row_reg;

    // Output register.
    logic                out_valid_reg;
    logic [NUM_KEYS-1:0] short_reg;
    logic [NUM_KEYS-1:0] long_reg;
    logic [1:0]          rstat_reg;

    logic                in_accept;
    logic                s1_advance;
    row_t                cur_row;
    row_t                row_next;
    logic [NUM_KEYS-1:0] short_next;
    logic [NUM_KEYS-1:0] long_next;
    logic [1:0]          rstat_next;

    // Handshake.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg  <= LONG_PRESS_RST;
            glitch_reg      <= GLITCH_RST;
            press_level_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LONG_PRESS: long_press_reg  <= cfg_data[LONG_W-1:0];
                CFG_GLITCH:     glitch_reg      <= cfg_data[GLITCH_W-1:0];
                CFG_PRESS_LVL:  press_level_reg <= cfg_data[NUM_KEYS-1:0];
                default:        ;
            endcase
        end
    end

    // Update stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            mem_written_reg <= 1'b0;
            fwd_hit_reg     <= 1'b0;
            rd_zero_reg     <= 1'b1;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
                // The row written at this same edge is not yet in the read data.
                fwd_hit_reg  <= s1_advance;
                rd_zero_reg  <= !mem_written_reg;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                mem_written_reg <= 1'b1;
            end
        end
    end

    // Update stage payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cmd_reg    <= cmd;
            s1_levels_reg <= key_levels;
            s1_idx_reg    <= key_index;
        end
    end

    // Memory read on acceptance and write-back from the update stage.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rd_data_reg <= state_mem[0];
        end
        if (s1_advance)
        begin
            state_mem[0] <= row_next;
            wb_row_reg   <= row_next;
        end
    end

    // Select the current row: forwarded, fresh from memory, or the reset row.
    always_comb
    begin
        if (fwd_hit_reg)
        begin
            cur_row = wb_row_reg;
        end
        else if (rd_zero_reg)
        begin
            cur_row = '0;
        end
        else
        begin
            cur_row = row_t'(rd_data_reg);
        end
    end

    // Per-key update; every key is handled in parallel.
    always_comb
    begin
        logic [LONG_W-1:0]   pc;
        logic [GLITCH_W-1:0] rc;
        row_next   = cur_row;
        short_next = '0;
        long_next  = '0;
        rstat_next = ST_NONE;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            pc = cur_row[k].pressed_count;
            rc = cur_row[k].released_count;
            if (s1_cmd_reg == CMD_TICK)
            begin
                if (s1_levels_reg[k] == press_level_reg[k])
                begin
                    // Pressed level: count up, drop the release count, check long.
                    if (pc != PRESSED_MAX)
                    begin
                        pc = pc + LONG_W'(1);
                    end
                    if (pc > LONG_W'(glitch_reg))
                    begin
                        row_next[k].released_count = '0;
                    end
                    if (pc > long_press_reg)
                    begin
                        pc = '0;
                        row_next[k].current_status = ST_LONG;
                        row_next[k].latched_status = ST_LONG;
                        long_next[k] = 1'b1;
                    end
                    row_next[k].pressed_count = pc;
                end
                else
                begin
                    // Released level: once stable, report a short press if due.
                    if (rc != RELEASED_MAX)
                    begin
                        rc = rc + GLITCH_W'(1);
                    end
                    row_next[k].released_count = rc;
                    if (rc > glitch_reg)
                    begin
                        if (cur_row[k].current_status == ST_NONE
                            && pc > LONG_W'(glitch_reg))
                        begin
                            row_next[k].current_status = ST_SHORT;
                            row_next[k].latched_status = ST_SHORT;
                            short_next[k] = 1'b1;
                        end
                        else
                        begin
                            row_next[k].current_status = ST_NONE;
                        end
                        row_next[k].released_count = '0;
                        row_next[k].pressed_count  = '0;
                    end
                end
            end
            else if (s1_idx_reg == IDX_W'(k))
            begin
                // Read and clear the latched status of the addressed key.
                rstat_next = cur_row[k].latched_status;
                row_next[k].latched_status = ST_NONE;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            short_reg <= short_next;
            long_reg  <= long_next;
            rstat_reg <= rstat_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign short_mask  = short_reg;
    assign long_mask   = long_reg;
    assign read_status = rstat_reg;

endmodule
